// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker module of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("checker: same-cycle implication violated");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("checker: next-cycle implication violated");

`endif

// ===== rtl/cdsd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdsd_pkg
// Types, constants and month-length helpers for the date shift block.
// ----------------------------------------------------------------------------
package cdsd_pkg;

    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned OFF_W   = 16;
    // running day value: day plus offset, signed
    localparam int unsigned DACC_W  = 17;

    localparam logic [YEAR_W-1:0]  YEAR_MIN   = 14'd1;
    localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd9999;
    localparam logic signed [OFF_W-1:0] MAX_OFFSET = 16'sd32767;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    // floor(2^19 / 100): y * RECIP_100 >> 19 is y/100 or one short, y < 2^14
    localparam logic [12:0] RECIP_100 = 13'd5242;
    localparam int unsigned RECIP_SH  = 19;

    typedef struct packed {
        logic [YEAR_W-1:0]       year_in;
        logic [MONTH_W-1:0]      month_in;
        logic [DAY_W-1:0]        day_in;
        logic signed [OFF_W-1:0] offset_days;
    } t_cdsd_req;

    typedef struct packed {
        logic [YEAR_W-1:0]  year_out;
        logic [MONTH_W-1:0] month_out;
        logic [DAY_W-1:0]   day_out;
        logic               out_of_range;
    } t_cdsd_res;

    // Gregorian leap rule from year split as (hi * 100 + lo)
    function automatic logic leap_year(input logic [6:0] lo, input logic [7:0] hi);
        leap_year = ((lo != 7'd0) && (lo[1:0] == 2'd0)) ||
                    ((lo == 7'd0) && (hi[1:0] == 2'd0));
    endfunction

    // Days in month; codes outside 1..12 give 31
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        len = 5'd31;
        case (m) inside
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
            MONTH_FEB: len = leap ? 5'd29 : 5'd28;
            default:   len = 5'd31;
        endcase
        month_len = len;
    endfunction

endpackage

// ===== rtl/calendar_date_shift_days_top.sv =====
`timescale 1ns / 1ps
// Sequence: the word is taken in idle, then passes the multiply, split and check
// states before the month-step loop; a bad starting date ends at the check.
// Throughput: one word at a time; busy stays high from acceptance to the result.
// The result shows on o_res for one cycle with o_valid; it cannot be held off.
// Reset (i_rst_n low, synchronous) returns to idle and drops o_valid.
// ----------------------------------------------------------------------------
// calendar_date_shift_days_top
// Shifts a Gregorian date by a signed day count, one month per cycle.
// ----------------------------------------------------------------------------
module calendar_date_shift_days_top
    import cdsd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_cdsd_req i_req,
    output logic      busy,
    output logic      o_valid,
    output t_cdsd_res o_res
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_SPLIT = 3'd2;
    localparam logic [2:0] ST_CHECK = 3'd3;
    localparam logic [2:0] ST_RUN   = 3'd4;

    logic [2:0]               r_state, n_state;
    t_cdsd_req                r_req, n_req;
    logic [26:0]              r_prod, n_prod;
    logic [YEAR_W-1:0]        r_year, n_year;
    logic [MONTH_W-1:0]       r_month, n_month;
    logic signed [DACC_W-1:0] r_d, n_d;
    logic [6:0]               r_lo, n_lo;
    logic [7:0]               r_hi, n_hi;
    logic                     r_neg, n_neg;
    t_cdsd_res                r_res, n_res;
    logic                     r_valid, n_valid;

    logic [7:0]               q100;
    logic [YEAR_W-1:0]        rem100;
    logic                     leap_cur;
    logic [MONTH_W-1:0]       m_prev;
    logic [DAY_W-1:0]         len_cur, len_prev;
    logic signed [OFF_W-1:0]  off_sat;
    logic                     start_ok;

    // year split: estimate of year / 100 from the registered product
    assign q100     = r_prod[RECIP_SH +: 8];
    assign rem100   = r_req.year_in - YEAR_W'(q100) * YEAR_W'(100);
    assign leap_cur = leap_year(r_lo, r_hi);
    assign m_prev   = (r_month == MONTH_JAN) ? MONTH_DEC : r_month - 4'd1;
    assign len_cur  = month_len(r_month, leap_cur);
    // stepping back from March keeps the year, so the current leap flag holds
    assign len_prev = month_len(m_prev, leap_cur);

    // offset clamped to +/- MAX_OFFSET
    always_comb begin
        if (r_req.offset_days > MAX_OFFSET) begin
            off_sat = MAX_OFFSET;
        end else if (r_req.offset_days < -MAX_OFFSET) begin
            off_sat = -MAX_OFFSET;
        end else begin
            off_sat = r_req.offset_days;
        end
    end

    // starting date validity
    assign start_ok = (r_req.year_in >= YEAR_MIN) && (r_req.year_in <= YEAR_MAX) &&
                      (r_req.month_in >= MONTH_JAN) && (r_req.month_in <= MONTH_DEC) &&
                      (r_req.day_in != 5'd0) && (r_req.day_in <= len_cur);

    // sequencer
    always_comb begin
        n_state = r_state;
        n_req   = r_req;
        n_prod  = r_prod;
        n_year  = r_year;
        n_month = r_month;
        n_d     = r_d;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_neg   = r_neg;
        n_res   = r_res;
        n_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_req   = i_req;
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_prod  = 27'(r_req.year_in) * 27'(RECIP_100);
                n_state = ST_SPLIT;
            end
            ST_SPLIT: begin
                if (rem100 >= YEAR_W'(100)) begin
                    n_lo = 7'(rem100 - YEAR_W'(100));
                    n_hi = q100 + 8'd1;
                end else begin
                    n_lo = 7'(rem100);
                    n_hi = q100;
                end
                n_year  = r_req.year_in;
                n_month = r_req.month_in;
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                n_d   = $signed({12'd0, r_req.day_in}) + DACC_W'(off_sat);
                n_neg = off_sat[OFF_W-1];
                if (start_ok) begin
                    n_state = ST_RUN;
                end else begin
                    n_res   = '{r_req.year_in, r_req.month_in, r_req.day_in, 1'b1};
                    n_valid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_RUN: begin
                if (!r_neg) begin
                    // forward: remove this month's length, advance the month
                    if (r_d > $signed({12'd0, len_cur})) begin
                        n_d = r_d - $signed({12'd0, len_cur});
                        if (r_month == MONTH_DEC) begin
                            n_month = MONTH_JAN;
                            n_year  = r_year + 14'd1;
                            if (r_lo == 7'd99) begin
                                n_lo = 7'd0;
                                n_hi = r_hi + 8'd1;
                            end else begin
                                n_lo = r_lo + 7'd1;
                            end
                            if (r_year == YEAR_MAX) begin
                                n_res   = '{r_req.year_in, r_req.month_in,
                                            r_req.day_in, 1'b1};
                                n_valid = 1'b1;
                                n_state = ST_IDLE;
                            end
                        end else begin
                            n_month = r_month + 4'd1;
                        end
                    end else begin
                        n_res   = '{r_year, r_month, r_d[DAY_W-1:0], 1'b0};
                        n_valid = 1'b1;
                        n_state = ST_IDLE;
                    end
                end else begin
                    // backward: step to the previous month and add its length
                    if (r_d <= 0) begin
                        n_month = m_prev;
                        n_d     = r_d + $signed({12'd0, len_prev});
                        if (r_month == MONTH_JAN) begin
                            n_year = r_year - 14'd1;
                            if (r_lo == 7'd0) begin
                                n_lo = 7'd99;
                                n_hi = r_hi - 8'd1;
                            end else begin
                                n_lo = r_lo - 7'd1;
                            end
                            if (r_year == YEAR_MIN) begin
                                n_res   = '{r_req.year_in, r_req.month_in,
                                            r_req.day_in, 1'b1};
                                n_valid = 1'b1;
                                n_state = ST_IDLE;
                            end
                        end
                    end else begin
                        n_res   = '{r_year, r_month, r_d[DAY_W-1:0], 1'b0};
                        n_valid = 1'b1;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_prod  <= n_prod;
        r_year  <= n_year;
        r_month <= n_month;
        r_d     <= n_d;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_neg   <= n_neg;
        r_res   <= n_res;
    end

    assign busy    = (r_state != ST_IDLE);
    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ===== rtl/cdsd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdsd_checker
// Port-level checks on the date shift block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cdsd_checker
    import cdsd_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input logic      o_valid,
    input t_cdsd_res o_res
);

    // an accepted word keeps the block busy in the next cycle
    `ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)

    // a result strobe lasts one cycle only
    `ASSERT_NXT(a_valid_single, i_clk, i_rst_n, o_valid, !o_valid)

    // the result is shown with the block already idle
    `ASSERT_IMP(a_valid_idle, i_clk, i_rst_n, o_valid, !busy)

    // an in-range result carries a real month and day
    `ASSERT_IMP(a_res_date, i_clk, i_rst_n, o_valid && !o_res.out_of_range,
        (o_res.month_out >= MONTH_JAN) && (o_res.month_out <= MONTH_DEC) &&
        (o_res.day_out != 5'd0) && (o_res.year_out >= YEAR_MIN) &&
        (o_res.year_out <= YEAR_MAX))

endmodule

bind calendar_date_shift_days_top cdsd_checker u_cdsd_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid),
    .o_res   (o_res)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Gregorian date shift block. Date/offset words
// go in on the start/busy handshake; every accepted word is run through a
// behavioural date shifter in the bench, and each strobed result is checked
// field by field, in order, against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import cdsd_pkg::*;

    // generous cycle ceiling: ~560 words at worst-case month stepping plus gaps
    localparam int unsigned CYCLE_LIMIT = 3_000_000;
    localparam int unsigned RANDOM_WORDS = 540;

    // ------------------------------------------------------------------------
    // Predicted results, held in order of acceptance
    // ------------------------------------------------------------------------
    class shifted_date_board;
        t_cdsd_res pending_dates[$];
        int unsigned fails;

        function new();
            fails = 0;
        endfunction

        // Gregorian month length; anything outside 1..12 counts as 31
        static function int month_days(int y, int m);
            bit leap;
            leap = ((y % 4) == 0 && (y % 100) != 0) || ((y % 400) == 0);
            case (m)
                MONTH_FEB: return leap ? 29 : 28;
                MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: return 30;
                default: return 31;
            endcase
        endfunction

        // Walk the date a month at a time in the direction of the offset
        function t_cdsd_res shift_date(t_cdsd_req w);
            int y;
            int m;
            int d;
            int step;
            int lim;
            bit bad;
            t_cdsd_res res;
            y    = w.year_in;
            m    = w.month_in;
            d    = w.day_in;
            step = w.offset_days;
            lim  = MAX_OFFSET;
            if (step > lim) step = lim;
            if (step < -lim) step = -lim;
            bad = (y < YEAR_MIN) || (y > YEAR_MAX) || (m < MONTH_JAN) || (m > MONTH_DEC) ||
                  (d < 1) || (d > month_days(y, m));
            if (!bad && step > 0) begin
                d += step;
                while (d > month_days(y, m)) begin
                    d -= month_days(y, m);
                    m++;
                    if (m > MONTH_DEC) begin
                        y++;
                        m = MONTH_JAN;
                    end
                end
            end else if (!bad && step < 0) begin
                d += step;
                while (d <= 0) begin
                    m--;
                    if (m < MONTH_JAN) begin
                        y--;
                        m = MONTH_DEC;
                    end
                    d += month_days(y, m);
                end
            end
            if (y < YEAR_MIN || y > YEAR_MAX) bad = 1'b1;
            if (bad) begin
                res.year_out     = w.year_in;
                res.month_out    = w.month_in;
                res.day_out      = w.day_in;
                res.out_of_range = 1'b1;
            end else begin
                res.year_out     = y[YEAR_W-1:0];
                res.month_out    = m[MONTH_W-1:0];
                res.day_out      = d[DAY_W-1:0];
                res.out_of_range = 1'b0;
            end
            return res;
        endfunction

        function void note_request(t_cdsd_req w);
            pending_dates.push_back(shift_date(w));
        endfunction

        function void check_result(t_cdsd_res got);
            t_cdsd_res exp_res;
            if (pending_dates.size() == 0) begin
                $error("unexpected result word: %0d-%0d-%0d oor=%0b",
                       got.year_out, got.month_out, got.day_out, got.out_of_range);
                fails++;
                return;
            end
            exp_res = pending_dates.pop_front();
            if (got.year_out !== exp_res.year_out) begin
                $error("year_out: expected %0d, actual %0d", exp_res.year_out, got.year_out);
                fails++;
            end
            if (got.month_out !== exp_res.month_out) begin
                $error("month_out: expected %0d, actual %0d", exp_res.month_out, got.month_out);
                fails++;
            end
            if (got.day_out !== exp_res.day_out) begin
                $error("day_out: expected %0d, actual %0d", exp_res.day_out, got.day_out);
                fails++;
            end
            if (got.out_of_range !== exp_res.out_of_range) begin
                $error("out_of_range: expected %0b, actual %0b",
                       exp_res.out_of_range, got.out_of_range);
                fails++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    t_cdsd_req   i_req = '0;
    logic        busy;
    logic        o_valid;
    t_cdsd_res   o_res;
    int unsigned cycles = 0;

    shifted_date_board sb = new();

    calendar_date_shift_days_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Result monitor: strobe is sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check_result(o_res);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic t_cdsd_req make_word(int y, int m, int d, int off);
        t_cdsd_req w;
        w.year_in     = y[YEAR_W-1:0];
        w.month_in    = m[MONTH_W-1:0];
        w.day_in      = d[DAY_W-1:0];
        w.offset_days = off[OFF_W-1:0];
        return w;
    endfunction

    // Mostly legal dates with assorted offsets; the rest is raw noise
    function automatic t_cdsd_req random_word();
        int y;
        int m;
        int d;
        int off;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 88) begin
            case ($urandom_range(0, 4))
                0:       y = $urandom_range(1, 120);
                1:       y = $urandom_range(9880, 9999);
                default: y = $urandom_range(1, 9999);
            endcase
            m = $urandom_range(MONTH_JAN, MONTH_DEC);
            d = $urandom_range(1, shifted_date_board::month_days(y, m));
        end else begin
            y = $urandom_range(0, 16383);
            m = $urandom_range(0, 15);
            d = $urandom_range(0, 31);
        end
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            off = $urandom_range(0, 800);
        end else if (pick < 90) begin
            off = $urandom_range(0, 32768);
        end else begin
            off = $urandom_range(32700, 32768);
        end
        if ($urandom_range(0, 1)) off = -off;
        return make_word(y, m, d, off);
    endfunction

    // Present one word and hold it until it is taken; start stays high
    task automatic send_word(t_cdsd_req w);
        @(negedge i_clk);
        start <= 1'b1;
        i_req <= w;
        do @(posedge i_clk); while (busy);
        sb.note_request(w);
    endtask

    // Drop start between words when n is positive, with junk on the request bus meanwhile
    task automatic idle_for(int n);
        if (n > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            i_req <= t_cdsd_req'({$urandom(), $urandom()});
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // Hold off the sender until every predicted result has come back
    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending_dates.size() != 0) @(posedge i_clk);
    endtask

    function automatic int pick_gap(bit burst);
        int r;
        if (burst) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(20, 60);
    endfunction

    initial begin
        t_cdsd_req directed[$];
        bit burst;
        int i;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // leap rules, year roll both ways, range edges, saturation, bad dates
        directed.push_back(make_word(2000, MONTH_FEB, 28, 1));
        directed.push_back(make_word(1900, MONTH_FEB, 28, 1));
        directed.push_back(make_word(2024, MONTH_FEB, 29, 0));
        directed.push_back(make_word(2023, MONTH_DEC, 31, 1));
        directed.push_back(make_word(2024, MONTH_JAN, 1, -1));
        directed.push_back(make_word(2024, MONTH_MAR, 1, -1));
        directed.push_back(make_word(9999, MONTH_DEC, 31, 1));
        directed.push_back(make_word(1, MONTH_JAN, 1, -1));
        directed.push_back(make_word(1, MONTH_JAN, 1, 32767));
        directed.push_back(make_word(9999, MONTH_DEC, 31, -32767));
        directed.push_back(make_word(5000, MONTH_JUN, 15, -32768));
        directed.push_back(make_word(5000, MONTH_JUN, 15, 32767));
        directed.push_back(make_word(9950, MONTH_JAN, 31, 32767));
        directed.push_back(make_word(50, MONTH_DEC, 1, -32768));
        directed.push_back(make_word(0, MONTH_MAR, 10, 5));
        directed.push_back(make_word(16383, 15, 31, -1));
        directed.push_back(make_word(2020, 0, 10, 3));
        directed.push_back(make_word(2020, 13, 10, 3));
        directed.push_back(make_word(2020, MONTH_MAR, 0, 3));
        directed.push_back(make_word(2021, MONTH_APR, 31, 1));
        directed.push_back(make_word(2023, MONTH_FEB, 29, 1));
        directed.push_back(make_word(2024, MONTH_FEB, 30, -1));
        directed.push_back(make_word(2022, MONTH_JAN, 31, 0));
        directed.push_back(make_word(1, MONTH_JAN, 1, 0));

        foreach (directed[k]) begin
            send_word(directed[k]);
            idle_for(pick_gap(k < 8));
        end
        drain();

        // random words, with bursts of back-to-back traffic between gappy stretches
        burst = 1'b0;
        for (i = 0; i < RANDOM_WORDS; i++) begin
            if (i % 40 == 0) burst = ($urandom_range(0, 3) == 0);
            if (i == RANDOM_WORDS / 2) drain();
            send_word(random_word());
            idle_for(pick_gap(burst));
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending_dates.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (sb.fails == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
